// ===== rtl/core/ups_power_sequencer_core_assert.svh =====
// Assertion macros for the power sequencer core.
// No dependencies; the top level includes this header.
`ifndef UPS_POWER_SEQUENCER_CORE_ASSERT_SVH
`define UPS_POWER_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define UPS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define UPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/upsseq_pkg.sv =====
// Shared types and constants for the power sequencer core.
// No dependencies; used by every module of the block.
package upsseq_pkg;

  localparam int unsigned VoltW = 16;
  localparam int unsigned SecW  = 7;
  localparam int unsigned IdxW  = 3;

  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_CHARGING = 2'd1,
    MODE_NORMAL   = 2'd2,
    MODE_OFF      = 2'd3
  } mode_t;

  // Configuration register indexes
  localparam logic [IdxW-1:0] REG_MIN_OFF   = 3'd0;
  localparam logic [IdxW-1:0] REG_START_THR = 3'd1;
  localparam logic [IdxW-1:0] REG_MAX_DROP  = 3'd2;
  localparam logic [IdxW-1:0] REG_WARNING   = 3'd3;
  localparam logic [IdxW-1:0] REG_RESTART   = 3'd4;
  localparam logic [IdxW-1:0] REG_SHUTDOWN  = 3'd5;

  // Reset values
  localparam logic [SecW-1:0]  RST_MIN_OFF   = 7'd10;
  localparam logic [VoltW-1:0] RST_START_THR = 16'd12000;
  localparam logic [VoltW-1:0] RST_MAX_DROP  = 16'd500;
  localparam logic [VoltW-1:0] RST_WARNING   = 16'd11000;
  localparam logic [SecW-1:0]  RST_RESTART   = 7'd30;
  localparam logic [VoltW-1:0] RST_SHUTDOWN  = 16'd10500;

  localparam logic [SecW-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [SecW-1:0]  min_off_seconds;
    logic [VoltW-1:0] start_threshold_mv;
    logic [VoltW-1:0] drop_limit_mv;
    logic [VoltW-1:0] warning_mv;
    logic [SecW-1:0]  restart_seconds;
    logic [VoltW-1:0] shutdown_mv;
  } cfg_t;

  typedef struct packed {
    mode_t            mode;
    logic             loop_relay;
    logic             main_relay;
    logic             ext_relay;
    logic [VoltW-1:0] peak_mv;
  } result_t;

endpackage

// ===== rtl/core/upsseq_cfg_regs.sv =====
// Configuration register file of the power sequencer.
// Depends on upsseq_pkg for register indexes and reset values.
module upsseq_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [upsseq_pkg::IdxW-1:0]   wr_index,
  input  logic [upsseq_pkg::VoltW-1:0]  wr_data,
  output upsseq_pkg::cfg_t              cfg
);
  import upsseq_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_off_seconds    <= RST_MIN_OFF;
      cfg.start_threshold_mv <= RST_START_THR;
      cfg.drop_limit_mv      <= RST_MAX_DROP;
      cfg.warning_mv         <= RST_WARNING;
      cfg.restart_seconds    <= RST_RESTART;
      cfg.shutdown_mv        <= RST_SHUTDOWN;
    end else if (wr_en) begin
      case (wr_index)
        REG_MIN_OFF:   cfg.min_off_seconds    <= wr_data[SecW-1:0];
        REG_START_THR: cfg.start_threshold_mv <= wr_data;
        REG_MAX_DROP:  cfg.drop_limit_mv      <= wr_data;
        REG_WARNING:   cfg.warning_mv         <= wr_data;
        REG_RESTART:   cfg.restart_seconds    <= wr_data[SecW-1:0];
        REG_SHUTDOWN:  cfg.shutdown_mv        <= wr_data;
        default: begin
          // unmapped index: drop the write
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/upsseq_step.sv =====
// Mode machine, seconds counter, peak tracker and relay state.
// Depends on upsseq_pkg; computes one tick's update from the held sample.
module upsseq_step (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step_en,
  input  logic [upsseq_pkg::VoltW-1:0]  voltage,
  input  upsseq_pkg::cfg_t              cfg,
  output upsseq_pkg::result_t           result
);
  import upsseq_pkg::*;

  mode_t            mode, mode_next;
  logic [SecW-1:0]  seconds, seconds_next;
  logic [VoltW-1:0] peak, peak_next;
  logic [2:0]       relays, relays_next;   // {ext, main, loop}

  logic [VoltW-1:0] peak_tracked;
  logic [SecW-1:0]  seconds_inc;
  logic [VoltW:0]   drop_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_IDLE;
      seconds <= '0;
      peak    <= '0;
      relays  <= '0;
    end else if (step_en) begin
      mode    <= mode_next;
      seconds <= seconds_next;
      peak    <= peak_next;
      relays  <= relays_next;
    end
  end

  always_comb begin
    // peak follows a higher sample, else decays by one and stops at zero
    if (voltage > peak) begin
      peak_tracked = voltage;
    end else if (peak != '0) begin
      peak_tracked = peak - VoltW'(1);
    end else begin
      peak_tracked = peak;
    end
    seconds_inc = (seconds == COUNT_MAX) ? seconds : seconds + SecW'(1);
    drop_sum    = {1'b0, voltage} + {1'b0, cfg.drop_limit_mv};

    mode_next    = mode;
    seconds_next = seconds;
    peak_next    = peak_tracked;
    relays_next  = relays;

    case (mode)
      MODE_IDLE: begin
        peak_next = peak;
        if (seconds >= cfg.min_off_seconds) begin
          peak_next = voltage;
          mode_next = MODE_CHARGING;
        end else begin
          seconds_next = seconds_inc;
        end
      end
      MODE_CHARGING: begin
        if (voltage > cfg.start_threshold_mv) begin
          relays_next = 3'b111;
          mode_next   = MODE_NORMAL;
        end
      end
      MODE_NORMAL: begin
        // drop test uses the peak after this tick's update
        if (drop_sum < {1'b0, peak_tracked} || voltage < cfg.warning_mv) begin
          relays_next[0] = 1'b0;
          mode_next      = MODE_OFF;
          seconds_next   = '0;
        end
      end
      MODE_OFF: begin
        if (seconds >= cfg.restart_seconds || voltage < cfg.shutdown_mv) begin
          relays_next[2:1] = 2'b00;
          mode_next        = MODE_IDLE;
        end else begin
          seconds_next = seconds_inc;
        end
      end
      default: begin
        mode_next = MODE_IDLE;
      end
    endcase

    result.mode       = mode_next;
    result.loop_relay = relays_next[0];
    result.main_relay = relays_next[1];
    result.ext_relay  = relays_next[2];
    result.peak_mv    = peak_next;
  end

endmodule

// ===== rtl/core/ups_power_sequencer_core.sv =====
// Top level of the backup-supply power sequencer.
// Depends on upsseq_pkg, upsseq_cfg_regs, upsseq_step and the assert header.
//
// Usage:
//   Input channel (in_valid, in_stall, voltage_mv) carries one supply sample
//   per one-second tick. Output channel (out_valid, out_stall, mode, relays,
//   peak_mv) returns one result per sample: the mode and relay drives after
//   the tick and the tracked peak.
//   Configuration writes go over cfg_valid/cfg_ready with cfg_index and
//   cfg_data; cfg_ready is always high. Write only while the block is idle.
// Path: a sample accepted into the input register is stepped, and its result
//   is presented from the result register once that register loads it.
// Throughput: one sample per cycle unless out_stall holds the result; the
//   mode and peak update runs from input register via step logic into state.
// Reset: mode idle, counter and peak zero, relays off, registers at their
//   defaults, both pipeline stages empty.
// Stall: while out_stall holds a result, one more sample is taken into the
//   input register; after that in_stall is raised until the result leaves.
module ups_power_sequencer_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [upsseq_pkg::VoltW-1:0]  voltage_mv,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    mode,
  output logic                          loop_relay,
  output logic                          main_relay,
  output logic                          ext_relay,
  output logic [upsseq_pkg::VoltW-1:0]  peak_mv,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [upsseq_pkg::IdxW-1:0]   cfg_index,
  input  logic [upsseq_pkg::VoltW-1:0]  cfg_data
);
  import upsseq_pkg::*;

  `include "ups_power_sequencer_core_assert.svh"

  cfg_t             cfg;
  result_t          result;
  logic             s1_valid;
  logic [VoltW-1:0] s1_voltage;
  logic             advance;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !advance;

  upsseq_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  upsseq_step u_step (
    .clk     (clk),
    .rst     (rst),
    .step_en (advance),
    .voltage (s1_voltage),
    .cfg     (cfg),
    .result  (result)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_voltage <= voltage_mv;
    end
  end

  // result register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      mode       <= result.mode;
      loop_relay <= result.loop_relay;
      main_relay <= result.main_relay;
      ext_relay  <= result.ext_relay;
      peak_mv    <= result.peak_mv;
    end
  end

  `UPS_ASSERT_NOW(a_relays_off_early, clk, rst,
    out_valid && (mode == MODE_IDLE || mode == MODE_CHARGING),
    !loop_relay && !main_relay && !ext_relay, "relay on in idle or charging")

  `UPS_ASSERT_NOW(a_relays_on_normal, clk, rst,
    out_valid && mode == MODE_NORMAL,
    loop_relay && main_relay && ext_relay, "relay off in normal mode")

  `UPS_ASSERT_NEXT(a_step_delivers, clk, rst, advance, out_valid,
    "stepped transaction did not reach the result register")

endmodule
